// ===== rtl/csnc_pkg.sv =====
// Shared types and codes of the command stream nesting checker.
// Used by the top level and by its port checker; no dependencies.
package csnc_pkg;

  localparam int unsigned KindWidth = 5;
  localparam int unsigned ErrWidth  = 4;

  // op field: one command of the buffer, or end of buffer
  localparam logic OP_CMD = 1'b0;
  localparam logic OP_END = 1'b1;

  typedef enum logic [KindWidth-1:0] {
    CMD_OTHER        = 5'd0,
    CMD_BEGIN_PASS   = 5'd1,
    CMD_END_PASS     = 5'd2,
    CMD_BEGIN_SUB    = 5'd3,
    CMD_END_SUB      = 5'd4,
    CMD_SET_BLEND    = 5'd5,
    CMD_BEGIN_DEBUG  = 5'd6,
    CMD_END_DEBUG    = 5'd7,
    CMD_BEGIN_PIXBUF = 5'd8,
    CMD_END_PIXBUF   = 5'd9,
    CMD_PUSH_CAM     = 5'd10,
    CMD_POP_CAM      = 5'd11,
    CMD_PUSH_VP      = 5'd12,
    CMD_POP_VP       = 5'd13,
    CMD_BIND_PIPE    = 5'd14,
    CMD_DRAW         = 5'd15,
    CMD_BIND_DESC    = 5'd16,
    CMD_BLIT         = 5'd17
  } cmd_kind_e;

  typedef enum logic [ErrWidth-1:0] {
    ERR_NONE           = 4'd0,
    ERR_NO_END_PASS    = 4'd1,
    ERR_NO_BEGIN_PASS  = 4'd2,
    ERR_NO_END_SUB     = 4'd3,
    ERR_NO_BEGIN_SUB   = 4'd4,
    ERR_BLEND_NO_PASS  = 4'd5,
    ERR_DEBUG_SCOPE    = 4'd6,
    ERR_NO_END_PIXBUF  = 4'd7,
    ERR_NO_BEGIN_PIXBUF = 4'd8,
    ERR_CAMERA         = 4'd9,
    ERR_VIEWPORT       = 4'd10,
    ERR_NO_PIPELINE    = 4'd11,
    ERR_NO_DESCRIPTORS = 4'd12
  } err_e;

endpackage

// ===== rtl/command_stream_nesting_checker.sv =====
// Top level of the command stream nesting checker: input register, tracking state
// and result register. Depends on csnc_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per command: op_i = 0
//   for a command of the buffer with its command_kind_i, op_i = 1 to close the
//   buffer. Every input word yields exactly one result word on the output channel
//   (out_valid_o/out_ready_i): error_code_o holds the first error of the buffer so
//   far, is_final_o marks the result of an end-of-buffer word, whose code also
//   covers the checks for scopes left open. State clears after each end word.
//   Configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes
//   validation_enable; it is always ready. With it at 0 every code reads 0.
//   Path: an accepted word passes the input register, then the result register.
//   Throughput: one word per cycle while results are taken; the state update of one
//   command is combinational flag and counter logic, closed by the result register.
//   Reset: empty pipeline, all tracking state cleared, validation enabled.
//   Stall: a waiting result holds; one more word sits in the input register,
//   then in_ready_o drops until out_ready_i returns.
module command_stream_nesting_checker
  import csnc_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [KindWidth-1:0] command_kind_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ErrWidth-1:0]  error_code_o,
  output logic                 is_final_o
);

  localparam logic        [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);
  localparam logic        [DEPTH_BITS-1:0] UMax     = {DEPTH_BITS{1'b1}};
  localparam logic signed [DEPTH_BITS-1:0] SMax     = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] SMin     = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  logic enable_q;

  logic                 s1_valid_q;
  logic                 s1_op_q;
  logic [KindWidth-1:0] s1_kind_q;
  logic                 s1_adv;
  logic                 s1_fire;

  logic                out_valid_q;
  logic [ErrWidth-1:0] out_code_q;
  logic                out_final_q;

  logic pass_q, pass_d;
  logic sub_q, sub_d;
  logic pixbuf_q, pixbuf_d;
  logic pipe_q, pipe_d;
  logic desc_q, desc_d;
  logic        [DEPTH_BITS-1:0] debug_q, debug_d;
  logic signed [DEPTH_BITS-1:0] cam_q, cam_d;
  logic signed [DEPTH_BITS-1:0] vp_q, vp_d;
  err_e first_err_q, first_err_d;

  err_e cmd_err;
  err_e final_err;
  err_e code;

  assign cfg_ready_o = 1'b1;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // One command against the current state; state moves only when no error is raised
  always_comb begin
    cmd_err  = ERR_NONE;
    pass_d   = pass_q;
    sub_d    = sub_q;
    pixbuf_d = pixbuf_q;
    pipe_d   = pipe_q;
    desc_d   = desc_q;
    debug_d  = debug_q;
    cam_d    = cam_q;
    vp_d     = vp_q;
    unique case (s1_kind_q)
      CMD_BEGIN_PASS: begin
        if (pass_q) cmd_err = ERR_NO_END_PASS;
        else pass_d = 1'b1;
      end
      CMD_END_PASS: begin
        if (!pass_q) cmd_err = ERR_NO_BEGIN_PASS;
        else pass_d = 1'b0;
      end
      CMD_BEGIN_SUB: begin
        if (sub_q) cmd_err = ERR_NO_END_SUB;
        else sub_d = 1'b1;
      end
      CMD_END_SUB: begin
        if (!sub_q) cmd_err = ERR_NO_BEGIN_SUB;
        else sub_d = 1'b0;
      end
      CMD_SET_BLEND: begin
        if (!pass_q) cmd_err = ERR_BLEND_NO_PASS;
      end
      CMD_BEGIN_DEBUG: begin
        if (debug_q != UMax) debug_d = debug_q + DepthOne;
      end
      CMD_END_DEBUG: begin
        if (debug_q == '0) cmd_err = ERR_DEBUG_SCOPE;
        else debug_d = debug_q - DepthOne;
      end
      CMD_BEGIN_PIXBUF: begin
        if (pixbuf_q) cmd_err = ERR_NO_END_PIXBUF;
        else pixbuf_d = 1'b1;
      end
      CMD_END_PIXBUF: begin
        if (!pixbuf_q) cmd_err = ERR_NO_BEGIN_PIXBUF;
        else pixbuf_d = 1'b0;
      end
      CMD_PUSH_CAM: begin
        if (cam_q != SMax) cam_d = cam_q + DepthOne;
      end
      CMD_POP_CAM: begin
        if (cam_q != SMin) cam_d = cam_q - DepthOne;
      end
      CMD_PUSH_VP: begin
        if (vp_q != SMax) vp_d = vp_q + DepthOne;
      end
      CMD_POP_VP: begin
        if (vp_q != SMin) vp_d = vp_q - DepthOne;
      end
      CMD_BIND_PIPE: pipe_d = 1'b1;
      CMD_DRAW: begin
        if (!pipe_q) cmd_err = ERR_NO_PIPELINE;
      end
      CMD_BIND_DESC: desc_d = 1'b1;
      CMD_BLIT: begin
        if (!desc_q) cmd_err = ERR_NO_DESCRIPTORS;
      end
      default: ;  // other and unknown kinds have no effect
    endcase
  end

  always_comb begin
    priority if (pass_q)        final_err = ERR_NO_END_PASS;
    else if (sub_q)             final_err = ERR_NO_END_SUB;
    else if (pixbuf_q)          final_err = ERR_NO_END_PIXBUF;
    else if (debug_q != '0)     final_err = ERR_DEBUG_SCOPE;
    else if (cam_q != '0)       final_err = ERR_CAMERA;
    else if (vp_q != '0)        final_err = ERR_VIEWPORT;
    else                        final_err = ERR_NONE;
  end

  always_comb begin
    first_err_d = first_err_q;
    if (s1_op_q == OP_END) begin
      code        = (first_err_q != ERR_NONE) ? first_err_q : final_err;
      first_err_d = ERR_NONE;
    end else if (first_err_q == ERR_NONE) begin
      code        = cmd_err;
      first_err_d = cmd_err;
    end else begin
      code = first_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
      sub_q       <= 1'b0;
      pixbuf_q    <= 1'b0;
      pipe_q      <= 1'b0;
      desc_q      <= 1'b0;
      debug_q     <= '0;
      cam_q       <= '0;
      vp_q        <= '0;
      first_err_q <= ERR_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        first_err_q <= first_err_d;
        if (s1_op_q == OP_END) begin
          // close the buffer: drop all tracking
          pass_q   <= 1'b0;
          sub_q    <= 1'b0;
          pixbuf_q <= 1'b0;
          pipe_q   <= 1'b0;
          desc_q   <= 1'b0;
          debug_q  <= '0;
          cam_q    <= '0;
          vp_q     <= '0;
        end else if (first_err_q == ERR_NONE) begin
          pass_q   <= pass_d;
          sub_q    <= sub_d;
          pixbuf_q <= pixbuf_d;
          pipe_q   <= pipe_d;
          desc_q   <= desc_d;
          debug_q  <= debug_d;
          cam_q    <= cam_d;
          vp_q     <= vp_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q   <= op_i;
      s1_kind_q <= command_kind_i;
    end
    if (s1_fire) begin
      out_code_q  <= enable_q ? code : ERR_NONE;
      out_final_q <= s1_op_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign error_code_o = out_code_q;
  assign is_final_o   = out_final_q;

endmodule

// ===== rtl/csnc_checker.sv =====
// Port-level assertions for command_stream_nesting_checker, bound to the top level.
// Depends on csnc_pkg.
module csnc_checker
  import csnc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic                 cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 op_i,
  input logic [KindWidth-1:0] command_kind_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ErrWidth-1:0]  error_code_o,
  input logic                 is_final_o
);

  logic                en_q;
  logic [ErrWidth-1:0] sticky_q;
  logic                out_take;
  logic                in_take;

  assign out_take = out_valid_o && out_ready_i;
  assign in_take  = in_valid_i && in_ready_o;

  // Shadow the enable and the last reported error of the open buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b1;
      sticky_q <= ERR_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        en_q     <= cfg_data_i;
        sticky_q <= ERR_NONE;
      end else if (out_take) begin
        if (is_final_o) sticky_q <= ERR_NONE;
        else if (en_q && error_code_o != ERR_NONE) sticky_q <= error_code_o;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(error_code_o) && $stable(is_final_o))
    else $error("result word changed while stalled");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  a_disabled_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !en_q |-> error_code_o == ERR_NONE)
    else $error("error reported with validation disabled");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && en_q && sticky_q != ERR_NONE |-> error_code_o == sticky_q)
    else $error("first error of buffer not held");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_take, 2) || $past(in_valid_i, 2))
    else $error("result without an input word");

endmodule

bind command_stream_nesting_checker csnc_checker u_csnc_checker (.*);
